FILE: rtl/mf3_pkg.sv
// Package: shared types, constants and the min, max and median helpers for the 3x3 median filter.
package mf3_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;
  localparam int CFG_W          = 12;
  localparam int CRD_W          = 11;
  localparam int PIX_W          = 24;

  localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [CRD_W-1:0] row;
    logic [CRD_W-1:0] col;
    pixel_t           pix;
    logic             run_last;
    logic             frame_done;
  } result_t;

  // Job passed from the front end to the back end
  typedef struct packed {
    logic   do_med;
    logic   do_pass;
    logic   last_frame;
    logic [CRD_W-1:0] row;
    logic [CRD_W-1:0] col;
    pixel_t pix;
    pixel_t w0, w1, w2, w3, w4, w5, top, mid;
  } job_t;

  function automatic logic [7:0] max2(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [7:0] min2(input logic [7:0] a, input logic [7:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [7:0] max3(input logic [7:0] a, b, c);
    return max2(max2(a, b), c);
  endfunction

  function automatic logic [7:0] min3(input logic [7:0] a, b, c);
    return min2(min2(a, b), c);
  endfunction

  function automatic logic [7:0] med3(input logic [7:0] a, b, c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

endpackage

FILE: rtl/mf3_stream_if.sv
// Interface: valid/ready stream channel with a typed payload.
interface mf3_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/mf3_front.sv
// Front end: position counters, line stores, window and work classification.
module mf3_front import mf3_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CFG_W-1:0] frame_width,
  input  logic [CFG_W-1:0] frame_height,
  input  logic             in_valid,
  output logic             in_ready,
  input  pixel_t           in_pix,
  output logic             job_valid,
  input  logic             job_ready,
  output job_t             job
);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  // Stage 1 holds the accepted pixel while the line stores are read
  logic             s1_v_r;
  pixel_t           s1_pix_r;
  logic [CW-1:0]    s1_col_r;
  logic [RW-1:0]    s1_row_r;
  logic             s1_lc_r, s1_lr_r;
  logic [CW-1:0]    col_r, col_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic [CW-1:0]    w_eff;
  logic [RW-1:0]    h_eff;
  logic             lc, lr, take, adv;
  pixel_t           up_mem [MAX_WIDTH];
  pixel_t           md_mem [MAX_WIDTH];
  pixel_t           top_q, mid_q;
  pixel_t           win_r [6];
  logic             job_v_r;
  job_t             job_r;

  // Clamp geometry
  always_comb begin
    if (frame_width == '0) w_eff = CW'(1);
    else if (32'(frame_width) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(frame_width);
    if (frame_height == '0) h_eff = RW'(1);
    else if (32'(frame_height) > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
    else h_eff = RW'(frame_height);
  end

  assign lc = (col_r >= w_eff - CW'(1));
  assign lr = (row_r >= h_eff - RW'(1));
  assign adv = !job_v_r || job_ready;
  assign in_ready = adv;
  assign take = in_valid && in_ready;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (take) begin
      if (lc) begin
        col_nxt = '0;
        row_nxt = lr ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (adv) s1_v_r <= take;
    end
  end

  // Capture the pixel and read both line stores
  always_ff @(posedge clk) begin
    if (take) begin
      s1_pix_r <= in_pix;
      s1_col_r <= col_r;
      s1_row_r <= row_r;
      s1_lc_r  <= lc;
      s1_lr_r  <= lr;
      top_q    <= up_mem[col_r[AW-1:0]];
      mid_q    <= md_mem[col_r[AW-1:0]];
    end
  end

  // Shift line stores behind the read; a read after write at the same column
  // occurs only in a one-column frame, where every pixel is a border pixel
  always_ff @(posedge clk) begin
    if (s1_v_r && adv) begin
      up_mem[s1_col_r[AW-1:0]] <= mid_q;
      md_mem[s1_col_r[AW-1:0]] <= s1_pix_r;
    end
  end

  // Window shift and job register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else if (adv) begin
      job_v_r <= s1_v_r;
      if (s1_v_r) begin
        win_r[0] <= win_r[3];
        win_r[1] <= win_r[4];
        win_r[2] <= win_r[5];
        win_r[3] <= top_q;
        win_r[4] <= mid_q;
        win_r[5] <= s1_pix_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_v_r) begin
      job_r.do_med     <= (s1_row_r >= RW'(2)) && (s1_col_r >= CW'(2));
      job_r.do_pass    <= (s1_row_r == '0) || (s1_col_r == '0) || s1_lc_r || s1_lr_r;
      job_r.last_frame <= s1_lc_r && s1_lr_r;
      job_r.row        <= CRD_W'(s1_row_r);
      job_r.col        <= CRD_W'(s1_col_r);
      job_r.pix        <= s1_pix_r;
      job_r.w0         <= win_r[0];
      job_r.w1         <= win_r[1];
      job_r.w2         <= win_r[2];
      job_r.w3         <= win_r[3];
      job_r.w4         <= win_r[4];
      job_r.w5         <= win_r[5];
      job_r.top        <= top_q;
      job_r.mid        <= mid_q;
    end
  end

  assign job_valid = job_v_r;
  assign job       = job_r;
endmodule

FILE: rtl/mf3_queue.sv
// Queue: two-entry FIFO between front end and back end.
module mf3_queue import mf3_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  job_t in_job,
  output logic out_valid,
  input  logic out_ready,
  output job_t out_job
);
  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_ready  = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_job   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_job;
  end
endmodule

FILE: rtl/mf3_back.sv
// Back end: per-channel median network and result sequencing.
module mf3_back import mf3_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    job_valid,
  output logic    job_ready,
  input  job_t    job,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);
  // Median stage 1: column sort terms per channel
  logic       m1_v_r;
  job_t       m1_job_r;
  logic [7:0] lo_r [3][3], md_r [3][3], hi_r [3][3];
  logic [7:0] med_c [3];
  logic       adv1, phase_r, out_v_r, out_go;
  result_t    out_r;

  function automatic logic [7:0] ch(input pixel_t p, input int k);
    return p[8*k +: 8];
  endfunction

  // Result register advances when empty or taken
  assign out_go = !out_v_r || res_ready;
  // Stage 1 frees when its job has issued its last result
  logic m1_done;
  assign m1_done = out_go && (!(m1_job_r.do_med && m1_job_r.do_pass) || phase_r);
  assign adv1    = !m1_v_r || m1_done;
  assign job_ready = adv1;

  always_ff @(posedge clk) begin
    if (adv1 && job_valid) begin
      m1_job_r <= job;
      for (int k = 0; k < 3; k++) begin
        lo_r[k][0] <= min3(ch(job.w0,k), ch(job.w1,k), ch(job.w2,k));
        md_r[k][0] <= med3(ch(job.w0,k), ch(job.w1,k), ch(job.w2,k));
        hi_r[k][0] <= max3(ch(job.w0,k), ch(job.w1,k), ch(job.w2,k));
        lo_r[k][1] <= min3(ch(job.w3,k), ch(job.w4,k), ch(job.w5,k));
        md_r[k][1] <= med3(ch(job.w3,k), ch(job.w4,k), ch(job.w5,k));
        hi_r[k][1] <= max3(ch(job.w3,k), ch(job.w4,k), ch(job.w5,k));
        lo_r[k][2] <= min3(ch(job.top,k), ch(job.mid,k), ch(job.pix,k));
        md_r[k][2] <= med3(ch(job.top,k), ch(job.mid,k), ch(job.pix,k));
        hi_r[k][2] <= max3(ch(job.top,k), ch(job.mid,k), ch(job.pix,k));
      end
    end
  end

  // Median of nine: med of (max of mins, med of meds, min of maxes)
  always_comb begin
    for (int k = 0; k < 3; k++)
      med_c[k] = med3(max3(lo_r[k][0], lo_r[k][1], lo_r[k][2]),
                      med3(md_r[k][0], md_r[k][1], md_r[k][2]),
                      min3(hi_r[k][0], hi_r[k][1], hi_r[k][2]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r  <= 1'b0;
      phase_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (out_go) out_v_r <= m1_v_r && (m1_job_r.do_med || m1_job_r.do_pass);
      if (m1_v_r && out_go) phase_r <= m1_done ? 1'b0 : 1'b1;
      if (adv1) m1_v_r <= job_valid;
    end
  end

  // Emit median first, then pass-through
  always_ff @(posedge clk) begin
    if (out_go && m1_v_r) begin
      if (m1_job_r.do_med && !phase_r) begin
        out_r.row        <= m1_job_r.row - CRD_W'(1);
        out_r.col        <= m1_job_r.col - CRD_W'(1);
        out_r.pix        <= {med_c[2], med_c[1], med_c[0]};
        out_r.run_last   <= !m1_job_r.do_pass;
        out_r.frame_done <= !m1_job_r.do_pass && m1_job_r.last_frame;
      end else begin
        out_r.row        <= m1_job_r.row;
        out_r.col        <= m1_job_r.col;
        out_r.pix        <= m1_job_r.pix;
        out_r.run_last   <= 1'b1;
        out_r.frame_done <= m1_job_r.last_frame;
      end
    end
  end

  assign res_valid = out_v_r;
  assign res       = out_r;
endmodule

FILE: rtl/median_filter_3x3_rgb.sv
// Top level: streaming 3x3 RGB median filter with coordinate-tagged results.
// One pixel is accepted per clock in raster order while nothing downstream
// stalls. A border pixel is passed through, and the pixel at (r,c), r>=2 and
// c>=2, also yields the median for (r-1,c-1), which comes first; such a pixel
// holds the back end until both of its results have issued, which slows the
// input on those rows' last column and the last row. The front end reads the
// line store memories through a register; a two-entry queue decouples it from
// the two-stage median network. frame_width and frame_height (0 read as 1,
// larger than the maximum read as the maximum) must be written only while the
// block is idle; the block itself does not enforce this.
module median_filter_3x3_rgb import mf3_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  mf3_stream_if.sink       in_ch,
  mf3_stream_if.source     out_ch
);
  logic [CFG_W-1:0] fw_r, fh_r;
  logic             fj_v, fj_r, qj_v, qj_r;
  job_t             fj, qj;
  result_t          res;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= CFG_W'(640);
      fh_r <= CFG_W'(480);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  fw_r <= cfg_data;
        REG_FRAME_HEIGHT: fh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  mf3_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst_n, .frame_width(fw_r), .frame_height(fh_r),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_pix(in_ch.data),
    .job_valid(fj_v), .job_ready(fj_r), .job(fj)
  );

  mf3_queue u_queue (
    .clk, .rst_n, .in_valid(fj_v), .in_ready(fj_r), .in_job(fj),
    .out_valid(qj_v), .out_ready(qj_r), .out_job(qj)
  );

  mf3_back u_back (
    .clk, .rst_n, .job_valid(qj_v), .job_ready(qj_r), .job(qj),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(res)
  );

  assign out_ch.data = res;

`ifndef ASSERT_OFF
  a_fd_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && res.frame_done |-> res.run_last)
    else $error("frame_done without run_last");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(res))
    else $error("stalled result changed");
`endif
endmodule

FILE: verif/mf3_checker.sv
`timescale 1ns / 1ps
// Checker for the 3x3 RGB median filter: tracks geometry, predicts results, compares them.
module mf3_checker import mf3_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  input  logic             in_ready,
  input  pixel_t           in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  result_t          out_data,
  output int               errors,
  output int               pending
);

  localparam int LINE_DEPTH = DEF_MAX_WIDTH;

  logic [CFG_W-1:0] width_reg, height_reg;
  pixel_t           upper_line [LINE_DEPTH];
  pixel_t           middle_line [LINE_DEPTH];
  pixel_t           window [6];
  int               col_pos, row_pos;
  result_t          expected_results [$];

  function automatic int clamp_size(input int v, input int lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  // Sort the nine samples and take the middle one
  function automatic logic [7:0] middle_of_nine(input logic [7:0] s [9]);
    logic [7:0] a [9];
    logic [7:0] v;
    int         j;
    a = s;
    for (int i = 1; i < 9; i++) begin
      v = a[i];
      j = i - 1;
      while (j >= 0 && a[j] > v) begin
        a[j + 1] = a[j];
        j--;
      end
      a[j + 1] = v;
    end
    return a[4];
  endfunction

  function automatic pixel_t median_pixel(input pixel_t nb [9]);
    logic [7:0] r [9], g [9], b [9];
    pixel_t     m;
    for (int i = 0; i < 9; i++) begin
      r[i] = nb[i].red;
      g[i] = nb[i].green;
      b[i] = nb[i].blue;
    end
    m.red   = middle_of_nine(r);
    m.green = middle_of_nine(g);
    m.blue  = middle_of_nine(b);
    return m;
  endfunction

  // Advance the filter model by one pixel and queue the results it causes
  task automatic filter_pixel(input pixel_t p);
    int      w, h, idx, n;
    pixel_t  top, mid;
    pixel_t  nb [9];
    result_t res [2];
    logic    last_col, last_row;
    w = clamp_size(width_reg, DEF_MAX_WIDTH);
    h = clamp_size(height_reg, DEF_MAX_HEIGHT);
    idx = col_pos % LINE_DEPTH;
    top = upper_line[idx];
    mid = middle_line[idx];
    last_col = (col_pos >= w - 1);
    last_row = (row_pos >= h - 1);
    n = 0;
    if (row_pos >= 2 && col_pos >= 2) begin
      for (int i = 0; i < 6; i++) nb[i] = window[i];
      nb[6] = top;
      nb[7] = mid;
      nb[8] = p;
      res[n] = '0;
      res[n].row = CRD_W'(row_pos - 1);
      res[n].col = CRD_W'(col_pos - 1);
      res[n].pix = median_pixel(nb);
      n++;
    end
    if (row_pos == 0 || col_pos == 0 || last_col || last_row) begin
      res[n] = '0;
      res[n].row = CRD_W'(row_pos);
      res[n].col = CRD_W'(col_pos);
      res[n].pix = p;
      n++;
    end
    // shift the window and the line stores
    for (int i = 0; i < 3; i++) window[i] = window[i + 3];
    window[3] = top;
    window[4] = mid;
    window[5] = p;
    upper_line[idx]  = mid;
    middle_line[idx] = p;
    if (n > 0) begin
      res[n - 1].run_last = 1'b1;
      if (last_col && last_row) res[n - 1].frame_done = 1'b1;
    end
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    for (int i = 0; i < n; i++) expected_results.push_back(res[i]);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  <= 12'd640;
      height_reg <= 12'd480;
      for (int i = 0; i < 6; i++) window[i] = '0;
      col_pos = 0;
      row_pos = 0;
      expected_results.delete();
    end else begin
      // track register writes
      if (cfg_we) begin
        if (cfg_index == REG_FRAME_WIDTH) width_reg <= cfg_data;
        else if (cfg_index == REG_FRAME_HEIGHT) height_reg <= cfg_data;
      end
      // predict from each input transaction
      if (in_valid && in_ready) filter_pixel(in_data);
      // compare each output transaction with the oldest expectation
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result row %0d col %0d", $time, out_data.row,
                   out_data.col);
        end else begin
          result_t e;
          e = expected_results.pop_front();
          if (out_data !== e) begin
            errors++;
            $display("%0t: mismatch expected r%0d c%0d rgb %h %h %h last %b done %b",
                     $time, e.row, e.col, e.pix.red, e.pix.green, e.pix.blue,
                     e.run_last, e.frame_done);
            $display("%0t:          actual   r%0d c%0d rgb %h %h %h last %b done %b",
                     $time, out_data.row, out_data.col, out_data.pix.red,
                     out_data.pix.green, out_data.pix.blue, out_data.run_last,
                     out_data.frame_done);
          end
        end
      end
    end
    pending = expected_results.size();
  end

  initial begin
    errors  = 0;
    pending = 0;
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Testbench top: drives frames and geometry into the median filter and gives the verdict.
module testbench;
  import mf3_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [0:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int               errors, pending;
  int               pixels_sent;
  logic             calm;
  logic             long_hold_done;
  int               idle_cycles;

  mf3_stream_if #(.payload_t(pixel_t))  in_ch ();
  mf3_stream_if #(.payload_t(result_t)) out_ch ();

  median_filter_3x3_rgb DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  mf3_checker u_checker (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_data(in_ch.data), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_data(out_ch.data), .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Hold off results in random bursts, once for a long stretch to back up the input
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!calm && !long_hold_done && pixels_sent > 150) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  // Count cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_pixel(input pixel_t p);
    logic rdy;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= p;
    do begin
      @(negedge clk);
      rdy = in_ch.ready;
      @(posedge clk);
    end while (!rdy);
    pixels_sent++;
  endtask

  // Wait for all results, let the pipeline drain, then set the geometry
  task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Push one whole frame; style 0 random, 1 alternating extremes, 2 ramp
  task automatic push_frame(input int w, input int h, input int style);
    int     cols, rows;
    pixel_t p;
    cols = (w == 0) ? 1 : (w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w;
    rows = (h == 0) ? 1 : (h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : h;
    set_geometry(CFG_W'(w), CFG_W'(h));
    for (int i = 0; i < cols * rows; i++) begin
      case (style)
        1: p = (i % 2 == 0) ? '1 : '0;
        2: p = {8'(i * 29), 8'(255 - i * 17), 8'(i * 7)};
        default: p = pixel_t'($urandom);
      endcase
      send_pixel(p);
    end
  endtask

  initial begin
    int w, h;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = REG_FRAME_WIDTH;
    cfg_data    = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    pixels_sent = 0;
    calm        = 1'b0;
    long_hold_done = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: smallest frames, extremes and the zero geometries
    push_frame(3, 3, 1);
    push_frame(1, 1, 1);
    push_frame(2, 2, 2);
    push_frame(4, 3, 2);
    push_frame(0, 5, 0);
    push_frame(6, 0, 0);

    // random frames, mostly small
    while (pixels_sent < 480) begin
      if (pixels_sent > 400) calm = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        w = $urandom_range(1, 3);
        h = $urandom_range(1, 12);
      end else begin
        w = $urandom_range(3, 16);
        h = $urandom_range(3, 10);
      end
      push_frame(w, h, ($urandom_range(0, 9) == 0) ? 1 : 0);
    end

    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
